@@ rtl/rv64sc_pkg.sv @@
`default_nettype none

package rv64sc_pkg;

    localparam int XLEN      = 64;
    localparam int PC_W      = 32;
    localparam int INSTR_W   = 32;
    localparam int MEM_BYTES = 1024;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int LANES     = 8;
    localparam int LANE_AW   = $clog2(LANES);
    localparam int ROWS      = MEM_BYTES / LANES;
    localparam int ROW_AW    = MEM_AW - LANE_AW;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int CLR_W     = (ROW_AW > REG_AW) ? ROW_AW : REG_AW;
    localparam int SADDR_W   = 10;

    typedef logic [XLEN-1:0]    t_xword;
    typedef logic [PC_W-1:0]    t_pc;
    typedef logic [MEM_AW-1:0]  t_maddr;
    typedef logic [ROW_AW-1:0]  t_row;
    typedef logic [LANE_AW-1:0] t_lane;
    typedef logic [REG_AW-1:0]  t_ridx;
    typedef logic [6:0]         t_opcode;
    typedef logic [2:0]         t_funct3;
    typedef logic [6:0]         t_funct7;

    localparam t_opcode OPC_LOAD   = 7'd3;
    localparam t_opcode OPC_OP_IMM = 7'd19;
    localparam t_opcode OPC_STORE  = 7'd35;
    localparam t_opcode OPC_OP     = 7'd51;
    localparam t_opcode OPC_BRANCH = 7'd99;

    localparam t_funct3 F3_ADD_SUB = 3'd0;
    localparam t_funct3 F3_SLL     = 3'd1;
    localparam t_funct3 F3_OR      = 3'd6;
    localparam t_funct3 F3_AND     = 3'd7;

    localparam t_funct7 F7_BASE = 7'd0;
    localparam t_funct7 F7_SUB  = 7'd32;

endpackage

`default_nettype wire

@@ rtl/rv64sc_ram.sv @@
`default_nettype none

module rv64sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/rv64_subset_single_cycle_core.sv @@
`default_nettype none

// Small RV64 core (add, sub, and, or, sll, addi, slli, ld, sd, beq) that executes one
// instruction word per transaction and returns one result transaction per instruction.
// It is a three-stage pipeline: register read, execute with data-memory access, then
// writeback/load alignment into the output register. One instruction is accepted every
// cycle while o_stall is low; o_valid rises once the instruction has passed the s1, s2
// and output registers, and apart from the clear pass the only back-pressure is the
// output stall. Register results and load data are forwarded, so no dependency stalls the
// pipeline. The data memory is eight byte-wide banks (one per byte lane) so an unaligned
// doubleword is one access. After reset the register file and data memory are zeroed by
// a clearing pass during which input is stalled; write the last-instruction-address
// register only while no instruction is in flight.
module rv64_subset_single_cycle_core
    import rv64sc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [31:0]             i_cfg_wdata,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [INSTR_W-1:0]      i_instr_word,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [PC_W-1:0]         o_next_pc,
    output logic                    o_reg_written,
    output logic [REG_AW-1:0]       o_dest_index,
    output logic signed [XLEN-1:0]  o_dest_value,
    output logic                    o_store_done,
    output logic [SADDR_W-1:0]      o_store_addr,
    output logic signed [XLEN-1:0]  o_store_data,
    output logic                    o_bad_opcode,
    output logic                    o_halted
);

    function automatic t_row lane_row(t_maddr addr, t_lane lane);
        t_row base;
        base = addr[MEM_AW-1:LANE_AW];
        return (lane < addr[LANE_AW-1:0]) ? t_row'(base + t_row'(1)) : base;
    endfunction

    // control
    logic                r_clearing;
    logic [CLR_W-1:0]    r_clr;
    logic [PC_W-1:0]     r_last;
    t_pc                 r_pc;
    logic                r_s1_valid;
    logic                r_s2_valid;
    logic                r_out_valid;
    logic                r_byp_valid;

    // payload
    logic [INSTR_W-1:0]  r_s1_instr;
    logic                r_s2_wr;
    t_ridx               r_s2_rd;
    logic                r_s2_load;
    t_xword              r_s2_alu;
    t_maddr              r_s2_maddr;
    logic                r_s2_st;
    logic [SADDR_W-1:0]  r_s2_saddr;
    t_xword              r_s2_sdata;
    logic                r_s2_bad;
    t_pc                 r_s2_next;
    logic                r_s2_halted;
    t_ridx               r_byp_idx;
    t_xword              r_byp_data;

    logic                r_out_wr;
    t_ridx               r_out_rd;
    t_xword              r_out_value;
    logic                r_out_st;
    logic [SADDR_W-1:0]  r_out_saddr;
    t_xword              r_out_sdata;
    logic                r_out_bad;
    t_pc                 r_out_next;
    logic                r_out_halted;

    logic                adv;
    logic                accept;

    // execute stage
    t_opcode             s1_opc;
    t_ridx               s1_rd;
    t_funct3             s1_f3;
    t_ridx               s1_rs1;
    t_ridx               s1_rs2;
    t_funct7             s1_f7;
    t_xword              imm_i;
    t_xword              imm_s;
    t_pc                 imm_b;
    t_xword              rf_a_rdata;
    t_xword              rf_b_rdata;
    t_xword              op_a;
    t_xword              op_b;
    t_xword              s1_mimm;
    t_maddr              s1_maddr;
    t_xword              s1_res;
    logic                s1_wr;
    logic                s1_wr_q;
    logic                s1_load;
    logic                s1_st;
    logic                s1_bad;
    t_pc                 s1_next;

    t_xword              ld_data;
    t_xword              s2_res;

    logic                rf_we;
    t_ridx               rf_waddr;
    t_xword              rf_wdata;
    t_ridx               rf_a_raddr;
    t_ridx               rf_b_raddr;

    logic                dm_we    [LANES];
    t_row                dm_waddr [LANES];
    logic [7:0]          dm_wdata [LANES];
    t_row                dm_raddr [LANES];
    logic [7:0]          dm_rdata [LANES];

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = r_clearing || !adv;
    assign accept  = i_valid && !o_stall;

    // register file: two copies, one per read port
    always_comb begin
        if (r_clearing) begin
            rf_we    = 1'b1;
            rf_waddr = r_clr[REG_AW-1:0];
            rf_wdata = '0;
        end else begin
            rf_we    = adv && r_s2_valid && r_s2_wr;
            rf_waddr = r_s2_rd;
            rf_wdata = s2_res;
        end
    end

    assign rf_a_raddr = adv ? i_instr_word[19:15] : s1_rs1;
    assign rf_b_raddr = adv ? i_instr_word[24:20] : s1_rs2;

    rv64sc_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rf_a_raddr),
        .o_rdata (rf_a_rdata)
    );

    rv64sc_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rf_b_raddr),
        .o_rdata (rf_b_rdata)
    );

    // decode / execute
    assign s1_opc = r_s1_instr[6:0];
    assign s1_rd  = r_s1_instr[11:7];
    assign s1_f3  = r_s1_instr[14:12];
    assign s1_rs1 = r_s1_instr[19:15];
    assign s1_rs2 = r_s1_instr[24:20];
    assign s1_f7  = r_s1_instr[31:25];

    assign imm_i = {{52{r_s1_instr[31]}}, r_s1_instr[31:20]};
    assign imm_s = {{52{r_s1_instr[31]}}, r_s1_instr[31:25], r_s1_instr[11:7]};
    assign imm_b = {{19{r_s1_instr[31]}}, r_s1_instr[31], r_s1_instr[7],
                    r_s1_instr[30:25], r_s1_instr[11:8], 1'b0};

    always_comb begin
        if (r_s2_valid && r_s2_wr && r_s2_rd == s1_rs1) begin
            op_a = s2_res;
        end else if (r_byp_valid && r_byp_idx == s1_rs1) begin
            op_a = r_byp_data;
        end else begin
            op_a = rf_a_rdata;
        end
        if (r_s2_valid && r_s2_wr && r_s2_rd == s1_rs2) begin
            op_b = s2_res;
        end else if (r_byp_valid && r_byp_idx == s1_rs2) begin
            op_b = r_byp_data;
        end else begin
            op_b = rf_b_rdata;
        end
    end

    always_comb begin
        s1_wr   = 1'b0;
        s1_load = 1'b0;
        s1_st   = 1'b0;
        s1_bad  = 1'b0;
        s1_res  = '0;
        s1_mimm = imm_i;
        s1_next = r_pc + t_pc'(4);
        unique case (s1_opc)
            OPC_OP: begin
                s1_wr = 1'b1;
                if (s1_f7 == F7_BASE && s1_f3 == F3_ADD_SUB) begin
                    s1_res = op_a + op_b;
                end else if (s1_f7 == F7_SUB && s1_f3 == F3_ADD_SUB) begin
                    s1_res = op_a - op_b;
                end else if (s1_f7 == F7_BASE && s1_f3 == F3_AND) begin
                    s1_res = op_a & op_b;
                end else if (s1_f7 == F7_BASE && s1_f3 == F3_OR) begin
                    s1_res = op_a | op_b;
                end else if (s1_f7 == F7_BASE && s1_f3 == F3_SLL) begin
                    s1_res = op_a << op_b[5:0];
                end else begin
                    s1_wr  = 1'b0;
                    s1_bad = 1'b1;
                end
            end
            OPC_OP_IMM: begin
                s1_wr = 1'b1;
                if (s1_f3 == F3_ADD_SUB) begin
                    s1_res = op_a + imm_i;
                end else if (s1_f3 == F3_SLL) begin
                    s1_res = op_a << imm_i[5:0];
                end else begin
                    s1_wr  = 1'b0;
                    s1_bad = 1'b1;
                end
            end
            OPC_LOAD: begin
                s1_wr   = 1'b1;
                s1_load = 1'b1;
            end
            OPC_STORE: begin
                s1_st   = 1'b1;
                s1_mimm = imm_s;
            end
            OPC_BRANCH: begin
                if (op_a == op_b) begin
                    s1_next = r_pc + imm_b;
                end
            end
            default: begin
                s1_bad = 1'b1;
            end
        endcase
    end

    assign s1_wr_q  = s1_wr && (s1_rd != '0);
    assign s1_maddr = op_a[MEM_AW-1:0] + s1_mimm[MEM_AW-1:0];

    // data memory: one bank per byte lane
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        t_lane byte_sel;
        assign byte_sel = t_lane'(k) - s1_maddr[LANE_AW-1:0];

        always_comb begin
            if (r_clearing) begin
                dm_we[k]    = 1'b1;
                dm_waddr[k] = r_clr[ROW_AW-1:0];
                dm_wdata[k] = '0;
            end else begin
                dm_we[k]    = adv && r_s1_valid && s1_st;
                dm_waddr[k] = lane_row(s1_maddr, t_lane'(k));
                dm_wdata[k] = op_b[{byte_sel, 3'b000} +: 8];
            end
        end

        assign dm_raddr[k] = adv ? lane_row(s1_maddr, t_lane'(k))
                                 : lane_row(r_s2_maddr, t_lane'(k));

        rv64sc_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
            .i_clk   (i_clk),
            .i_we    (dm_we[k]),
            .i_waddr (dm_waddr[k]),
            .i_wdata (dm_wdata[k]),
            .i_raddr (dm_raddr[k]),
            .o_rdata (dm_rdata[k])
        );
    end

    // load alignment
    always_comb begin
        t_lane li;
        for (int i = 0; i < LANES; i++) begin
            li = r_s2_maddr[LANE_AW-1:0] + t_lane'(i);
            ld_data[8*i +: 8] = dm_rdata[li];
        end
    end

    assign s2_res = r_s2_load ? ld_data : r_s2_alu;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr       <= '0;
            r_last      <= '0;
            r_pc        <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr <= r_clr + CLR_W'(1);
                if (&r_clr) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                r_last <= i_cfg_wdata;
            end
            r_byp_valid <= !r_clearing && adv && r_s2_valid && r_s2_wr;
            if (adv) begin
                r_s1_valid  <= accept;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid;
                if (r_s1_valid) begin
                    r_pc <= s1_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_byp_idx  <= r_s2_rd;
        r_byp_data <= s2_res;
        if (adv) begin
            r_s1_instr   <= i_instr_word;

            r_s2_wr      <= s1_wr_q;
            r_s2_rd      <= s1_rd;
            r_s2_load    <= s1_load;
            r_s2_alu     <= s1_res;
            r_s2_maddr   <= s1_maddr;
            r_s2_st      <= s1_st;
            r_s2_saddr   <= SADDR_W'(s1_maddr);
            r_s2_sdata   <= op_b;
            r_s2_bad     <= s1_bad;
            r_s2_next    <= s1_next;
            r_s2_halted  <= s1_next > r_last;

            r_out_wr     <= r_s2_wr;
            r_out_rd     <= r_s2_wr ? r_s2_rd : '0;
            r_out_value  <= r_s2_wr ? s2_res : '0;
            r_out_st     <= r_s2_st;
            r_out_saddr  <= r_s2_st ? r_s2_saddr : '0;
            r_out_sdata  <= r_s2_st ? r_s2_sdata : '0;
            r_out_bad    <= r_s2_bad;
            r_out_next   <= r_s2_next;
            r_out_halted <= r_s2_halted;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_next_pc     = r_out_next;
    assign o_reg_written = r_out_wr;
    assign o_dest_index  = r_out_rd;
    assign o_dest_value  = $signed(r_out_value);
    assign o_store_done  = r_out_st;
    assign o_store_addr  = r_out_saddr;
    assign o_store_data  = $signed(r_out_sdata);
    assign o_bad_opcode  = r_out_bad;
    assign o_halted      = r_out_halted;

endmodule

`default_nettype wire
